/* src/fifo_queue_lock_unit_assert.svh */
// Assertion macros shared by the lock unit RTL.
`ifndef FIFO_QUEUE_LOCK_UNIT_ASSERT_SVH
`define FIFO_QUEUE_LOCK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FQLU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fifo_queue_lock_unit: assertion failed");
`define FQLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fifo_queue_lock_unit: assertion failed");
`else
`define FQLU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FQLU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/fqlu_pkg.sv */
`timescale 1ns / 1ps
package fqlu_pkg;

  localparam int THREAD_COUNT_DEF = 16;
  localparam int THREAD_W = 4;

  localparam logic MODE_LOCK = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [THREAD_W-1:0] thread;
  } in_word_t;

  typedef struct packed {
    logic [THREAD_W-1:0] granted_thread;
    logic                by_release;
  } out_word_t;

endpackage

/* src/fqlu_ram.sv */
`timescale 1ns / 1ps
module fqlu_ram #(
  parameter int Width = 4,
  parameter int Depth = 33
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                        wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                        rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/fifo_queue_lock_unit.sv */
`timescale 1ns / 1ps
`include "fifo_queue_lock_unit_assert.svh"
// First-come first-served lock manager in the style of a CLH queue lock. Send a word with
// mode 0 to request the lock for a thread and mode 1 to release it. A result word names the
// thread that now holds the lock: by_release is 0 when a request was granted at once and 1
// when a release handed the lock to the next waiter. A request that must wait and a release
// with nobody waiting give no result, and thread numbers at or above THREAD_COUNT are dropped.
// The unit takes one word per cycle while the output register is empty or being read; each word
// is held in the input register until the output register can take its result. The waiter
// table is a RAM with a registered read, addressed as the word is taken in; its valid flags and
// the busy flags are flip-flops cleared by reset, so no clearing pass is needed.
module fifo_queue_lock_unit #(
  parameter int THREAD_COUNT = fqlu_pkg::THREAD_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fqlu_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fqlu_pkg::out_word_t out_data_o
);

  import fqlu_pkg::*;

  localparam int NodeCount = 2 * THREAD_COUNT + 1;
  localparam int TidW = THREAD_COUNT > 1 ? $clog2(THREAD_COUNT) : 1;
  localparam int NodeW = $clog2(NodeCount);
  localparam logic [NodeW-1:0] RootNode = NodeW'(2 * THREAD_COUNT);

  logic                   s1_valid_q, s1_valid_d;
  in_word_t               s1_word_q, s1_word_d;
  logic [THREAD_COUNT-1:0] phase_q, phase_d;
  logic [NodeCount-1:0]   busy_q, busy_d;
  logic [NodeCount-1:0]   wv_q, wv_d;
  logic [NodeW-1:0]       tail_q, tail_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;
  logic                   byp_q, byp_d;
  logic [THREAD_W-1:0]    byp_data_q, byp_data_d;

  logic                proceed;
  logic                accept;
  logic                in_range;
  logic [TidW-1:0]     s1_tid;
  logic                cur_phase;
  logic [NodeW-1:0]    lock_node;
  logic [NodeW-1:0]    own_node;
  logic                pred_busy;
  logic [THREAD_W-1:0] ram_rdata;
  logic [THREAD_W-1:0] waiter_data;
  logic                wr_en;
  logic [NodeW-1:0]    wr_addr;
  logic [THREAD_W-1:0] wr_data;
  logic [TidW-1:0]     rd_tid;
  logic [NodeW-1:0]    rd_addr;
  logic                res_valid;
  out_word_t           res_word;
  logic                grant_now;

  assign proceed = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | proceed;
  assign accept = in_valid_i & in_ready_o;

  assign in_range = 32'(s1_word_q.thread) < 32'(THREAD_COUNT);
  assign s1_tid = TidW'(s1_word_q.thread);
  assign cur_phase = phase_q[s1_tid];
  assign lock_node = NodeW'({s1_tid, ~cur_phase});
  assign own_node = NodeW'({s1_tid, cur_phase});
  assign pred_busy = (tail_q == lock_node) | busy_q[tail_q];
  assign waiter_data = byp_q ? byp_data_q : ram_rdata;
  assign grant_now = proceed && in_range && (s1_word_q.mode == MODE_LOCK) && !pred_busy;

  always_comb begin
    phase_d = phase_q;
    busy_d = busy_q;
    wv_d = wv_q;
    tail_d = tail_q;
    wr_en = 1'b0;
    wr_addr = tail_q;
    wr_data = s1_word_q.thread;
    res_valid = 1'b0;
    res_word = '0;
    if (proceed && in_range) begin
      case (s1_word_q.mode)
        MODE_LOCK: begin
          phase_d[s1_tid] = ~cur_phase;
          busy_d[lock_node] = 1'b1;
          tail_d = lock_node;
          if (!pred_busy) begin
            res_valid = 1'b1;
            res_word.granted_thread = s1_word_q.thread;
            res_word.by_release = 1'b0;
          end else begin
            wv_d[tail_q] = 1'b1;
            wr_en = 1'b1;
          end
        end
        MODE_UNLOCK: begin
          busy_d[own_node] = 1'b0;
          if (wv_q[own_node]) begin
            wv_d[own_node] = 1'b0;
            res_valid = 1'b1;
            res_word.granted_thread = waiter_data;
            res_word.by_release = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The waiter RAM is read as a word enters, using the phase it will see next cycle.
  assign rd_tid = TidW'(in_data_i.thread);
  assign rd_addr = NodeW'({rd_tid, phase_d[rd_tid]});

  always_comb begin
    byp_d = byp_q;
    byp_data_d = byp_data_q;
    if (accept) begin
      byp_d = wr_en && (wr_addr == rd_addr);
      byp_data_d = wr_data;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_word_d = s1_word_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_word_d = in_data_i;
    end else if (proceed) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d = out_word_q;
    if (proceed) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_word_d = res_word;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  fqlu_ram #(
    .Width(THREAD_W),
    .Depth(NodeCount)
  ) u_waiter_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .rd_data_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q <= '0;
      busy_q <= '0;
      wv_q <= '0;
      tail_q <= RootNode;
      out_valid_q <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      phase_q <= phase_d;
      busy_q <= busy_d;
      wv_q <= wv_d;
      tail_q <= tail_d;
      out_valid_q <= out_valid_d;
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_word_q <= s1_word_d;
    out_word_q <= out_word_d;
    byp_data_q <= byp_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_word_q;

  `FQLU_ASSERT_IMPL(a_default_free, clk_i, rst_ni, 1'b1, !busy_q[NodeCount-1])
  `FQLU_ASSERT_IMPL(a_waiter_on_busy, clk_i, rst_ni, 1'b1, (wv_q & ~busy_q) == '0)
  `FQLU_ASSERT_NEXT(a_grant_now, clk_i, rst_ni, grant_now, out_valid_o && out_data_o == $past(res_word))

endmodule
